>>> sv/rpn_pkg.sv
// Package for the reverse Polish evaluator: token, operator and status codes,
// stack sizing and fixed-point constants. No dependencies.
package rpn_pkg;
    localparam int STACK_DEPTH = 16;
    localparam int FRAC_BITS = 32;
    localparam int DATA_W = 64;
    localparam int PTR_W = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    typedef enum logic [1:0] {
        REQ_PUSH = 2'd0,
        REQ_OP = 2'd1,
        REQ_END = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_UNDER = 3'd1,
        ST_FULL = 3'd2,
        ST_DIV0 = 3'd3,
        ST_OVF = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_RD1, S_RD2, S_CALC, S_MUL1, S_MUL2, S_MUL3, S_DIV, S_FIN, S_WR, S_END, S_OUT
    } state_t;

    typedef enum logic [2:0] {
        A_IDLE, A_MUL0, A_MUL1, A_MULF, A_DIV, A_SAT
    } alu_state_t;

    typedef struct packed {
        logic start;
        logic [1:0] op;
        logic [DATA_W-1:0] left;
        logic [DATA_W-1:0] right;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic [DATA_W-1:0] value;
        logic [2:0] status;
    } alu_rsp_t;

    localparam logic [DATA_W-1:0] MAXPOS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] MINNEG = {1'b1, {(DATA_W-1){1'b0}}};
endpackage

>>> sv/rpn_alu.sv
// Multi-cycle fixed-point arithmetic unit: add, subtract, a multiply built
// from four 32x32 partial products, and a restoring divide. Uses rpn_pkg.
module rpn_alu (
    input  logic aclk,
    input  logic aresetn,
    input  rpn_pkg::alu_req_t req,
    output rpn_pkg::alu_rsp_t rsp
);
    rpn_pkg::alu_state_t st_reg, st_next;
    logic [63:0] ma_reg, mb_reg;
    logic neg_reg;
    logic [1:0] op_reg;
    logic [63:0] p_ll_reg, p_lh_reg, p_hl_reg, p_hh_reg;
    logic [127:0] acc_reg;
    logic [63:0] r_reg;
    logic [127:0] q_reg;
    logic [127:0] n_reg;
    logic [7:0] cnt_reg;
    logic [63:0] left_reg, right_reg;
    logic [63:0] out_reg;
    logic [2:0] ost_reg;
    logic done_reg;

    logic [63:0] ma_c, mb_c, sum_c, dif_c;
    logic [64:0] rsh_c;
    logic ge_c;
    logic [127:0] prod_c, shifted_c;
    logic [63:0] sat_v;
    logic sat_ovf;
    logic addsub_ovf;
    logic start_idle;

    assign start_idle = (st_reg == rpn_pkg::A_IDLE) && req.start;
    assign ma_c = req.left[63] ? (64'd0 - req.left) : req.left;
    assign mb_c = req.right[63] ? (64'd0 - req.right) : req.right;
    assign sum_c = left_reg + right_reg;
    assign dif_c = left_reg - right_reg;
    assign rsh_c = {r_reg, n_reg[127]};
    assign ge_c = rsh_c >= {1'b0, mb_reg};
    assign prod_c = {p_hh_reg, 64'd0} + {32'd0, p_lh_reg, 32'd0}
        + {32'd0, p_hl_reg, 32'd0} + {64'd0, p_ll_reg};
    assign shifted_c = prod_c >> rpn_pkg::FRAC_BITS;
    assign addsub_ovf = (op_reg == rpn_pkg::OP_ADD) ?
        (left_reg[63] == right_reg[63] && sum_c[63] != left_reg[63]) :
        (left_reg[63] != right_reg[63] && dif_c[63] != left_reg[63]);

    always_comb begin
        sat_ovf = 1'b0;
        sat_v = acc_reg[63:0];
        if (neg_reg) begin
            if (acc_reg[127:64] != 64'd0 || acc_reg[63:0] > rpn_pkg::MINNEG) begin
                sat_ovf = 1'b1;
                sat_v = rpn_pkg::MINNEG;
            end else begin
                sat_v = 64'd0 - acc_reg[63:0];
            end
        end else if (acc_reg[127:64] != 64'd0 || acc_reg[63:0] > rpn_pkg::MAXPOS) begin
            sat_ovf = 1'b1;
            sat_v = rpn_pkg::MAXPOS;
        end
    end

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            rpn_pkg::A_IDLE: begin
                if (req.start) begin
                    unique case (req.op)
                        rpn_pkg::OP_MUL: st_next = rpn_pkg::A_MUL0;
                        rpn_pkg::OP_DIV: st_next = (req.right == 64'd0) ?
                            rpn_pkg::A_IDLE : rpn_pkg::A_DIV;
                        default: st_next = rpn_pkg::A_SAT;
                    endcase
                end
            end
            rpn_pkg::A_MUL0: st_next = rpn_pkg::A_MUL1;
            rpn_pkg::A_MUL1: st_next = rpn_pkg::A_MULF;
            rpn_pkg::A_MULF: st_next = rpn_pkg::A_SAT;
            rpn_pkg::A_DIV: st_next = (cnt_reg == 8'd0) ? rpn_pkg::A_SAT : rpn_pkg::A_DIV;
            rpn_pkg::A_SAT: st_next = rpn_pkg::A_IDLE;
            default: st_next = rpn_pkg::A_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= rpn_pkg::A_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            done_reg <= (st_reg == rpn_pkg::A_SAT) ||
                (start_idle && req.op == rpn_pkg::OP_DIV && req.right == 64'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (start_idle) begin
            op_reg <= req.op;
            left_reg <= req.left;
            right_reg <= req.right;
            ma_reg <= ma_c;
            mb_reg <= mb_c;
            neg_reg <= req.left[63] ^ req.right[63];
            r_reg <= 64'd0;
            q_reg <= 128'd0;
            n_reg <= {64'd0, ma_c} << rpn_pkg::FRAC_BITS;
            cnt_reg <= 8'd127;
            if (req.op == rpn_pkg::OP_DIV && req.right == 64'd0) begin
                out_reg <= req.left[63] ? rpn_pkg::MINNEG : rpn_pkg::MAXPOS;
                ost_reg <= rpn_pkg::ST_DIV0;
            end
        end
        if (st_reg == rpn_pkg::A_MUL0) begin
            p_ll_reg <= ma_reg[31:0] * mb_reg[31:0];
            p_lh_reg <= ma_reg[31:0] * mb_reg[63:32];
        end
        if (st_reg == rpn_pkg::A_MUL1) begin
            p_hl_reg <= ma_reg[63:32] * mb_reg[31:0];
            p_hh_reg <= ma_reg[63:32] * mb_reg[63:32];
        end
        if (st_reg == rpn_pkg::A_MULF) begin
            acc_reg <= shifted_c;
        end
        if (st_reg == rpn_pkg::A_DIV) begin
            n_reg <= n_reg << 1;
            if (ge_c) begin
                r_reg <= rsh_c[63:0] - mb_reg;
            end else begin
                r_reg <= rsh_c[63:0];
            end
            q_reg <= {q_reg[126:0], ge_c};
            cnt_reg <= cnt_reg - 8'd1;
            if (cnt_reg == 8'd0) begin
                acc_reg <= {q_reg[126:0], ge_c};
            end
        end
        if (st_reg == rpn_pkg::A_SAT) begin
            case (op_reg) inside
                rpn_pkg::OP_ADD, rpn_pkg::OP_SUB: begin
                    if (addsub_ovf) begin
                        out_reg <= left_reg[63] ? rpn_pkg::MINNEG : rpn_pkg::MAXPOS;
                        ost_reg <= rpn_pkg::ST_OVF;
                    end else begin
                        out_reg <= (op_reg == rpn_pkg::OP_ADD) ? sum_c : dif_c;
                        ost_reg <= rpn_pkg::ST_OK;
                    end
                end
                default: begin
                    out_reg <= sat_v;
                    ost_reg <= sat_ovf ? rpn_pkg::ST_OVF : rpn_pkg::ST_OK;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.value = out_reg;
    assign rsp.status = ost_reg;
endmodule

>>> sv/rpn_stack_evaluator.sv
// Reverse Polish evaluator on a 16-entry operand stack held in a memory with
// a registered read port. A push is written in the cycle it is taken; an end
// token shows its word from the top of the stack, and the next token is taken
// only once that word is accepted. Divide is the longest operator, as it runs
// the 128-step bit-serial divider. Synchronous active-low reset empties the
// stack and clears the status, not the memory.
module rpn_stack_evaluator (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  logic [1:0] s_req_type,
    input  logic signed [63:0] s_operand_value,
    input  logic [1:0] s_op_code,
    output logic m_valid,
    input  logic m_ready,
    output logic signed [63:0] m_result_value,
    output logic [2:0] m_status
);
    rpn_pkg::state_t st_reg, st_next;
    logic [rpn_pkg::PTR_W-1:0] sp_reg;
    logic [2:0] sticky_reg;
    logic [1:0] op_reg;
    logic [63:0] right_reg, left_reg, res_reg;
    logic [63:0] mem [rpn_pkg::STACK_DEPTH];
    logic [63:0] rdata_reg;
    logic [rpn_pkg::ADDR_W-1:0] raddr;
    logic we;
    logic [rpn_pkg::ADDR_W-1:0] waddr;
    logic [63:0] wdata;
    logic mv_reg;
    logic [63:0] mval_reg;
    logic [2:0] mst_reg;
    rpn_pkg::alu_req_t areq;
    rpn_pkg::alu_rsp_t arsp;
    logic acc;

    rpn_alu u_alu (.aclk(aclk), .aresetn(aresetn), .req(areq), .rsp(arsp));

    assign s_ready = (st_reg == rpn_pkg::S_IDLE) && !mv_reg;
    assign acc = s_valid && s_ready;
    assign m_valid = mv_reg;
    assign m_result_value = mval_reg;
    assign m_status = mst_reg;

    always_comb begin
        raddr = '0;
        if (st_reg == rpn_pkg::S_IDLE) begin
            raddr = rpn_pkg::ADDR_W'(sp_reg - 1'b1);
        end else begin
            raddr = rpn_pkg::ADDR_W'(sp_reg - 2'd2);
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_comb begin
        st_next = st_reg;
        we = 1'b0;
        waddr = rpn_pkg::ADDR_W'(sp_reg);
        wdata = s_operand_value;
        areq.start = 1'b0;
        areq.op = op_reg;
        areq.left = left_reg;
        areq.right = right_reg;
        unique case (st_reg)
            rpn_pkg::S_IDLE: begin
                if (acc) begin
                    unique case (rpn_pkg::req_t'(s_req_type))
                        rpn_pkg::REQ_PUSH: begin
                            we = sp_reg < rpn_pkg::PTR_W'(rpn_pkg::STACK_DEPTH);
                        end
                        rpn_pkg::REQ_OP: begin
                            if (sp_reg >= rpn_pkg::PTR_W'(2)) begin
                                st_next = rpn_pkg::S_RD1;
                            end
                        end
                        rpn_pkg::REQ_END: st_next = rpn_pkg::S_END;
                        default: st_next = rpn_pkg::S_IDLE;
                    endcase
                end
            end
            rpn_pkg::S_RD1: st_next = rpn_pkg::S_RD2;
            rpn_pkg::S_RD2: st_next = rpn_pkg::S_CALC;
            rpn_pkg::S_CALC: begin
                areq.start = 1'b1;
                st_next = rpn_pkg::S_DIV;
            end
            rpn_pkg::S_DIV: begin
                if (arsp.done) begin
                    st_next = rpn_pkg::S_WR;
                end
            end
            rpn_pkg::S_WR: begin
                we = 1'b1;
                waddr = rpn_pkg::ADDR_W'(sp_reg - 1'b1);
                wdata = res_reg;
                st_next = rpn_pkg::S_IDLE;
            end
            rpn_pkg::S_END: st_next = rpn_pkg::S_IDLE;
            default: st_next = rpn_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= rpn_pkg::S_IDLE;
            sp_reg <= '0;
            sticky_reg <= rpn_pkg::ST_OK;
            mv_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (mv_reg && m_ready) begin
                mv_reg <= 1'b0;
            end
            if (acc) begin
                op_reg <= s_op_code;
                if (s_req_type == rpn_pkg::REQ_PUSH) begin
                    if (sp_reg < rpn_pkg::PTR_W'(rpn_pkg::STACK_DEPTH)) begin
                        sp_reg <= sp_reg + 1'b1;
                    end else if (sticky_reg == rpn_pkg::ST_OK) begin
                        sticky_reg <= rpn_pkg::ST_FULL;
                    end
                end
                if (s_req_type == rpn_pkg::REQ_OP && sp_reg < rpn_pkg::PTR_W'(2)
                    && sticky_reg == rpn_pkg::ST_OK) begin
                    sticky_reg <= rpn_pkg::ST_UNDER;
                end
            end
            if (st_reg == rpn_pkg::S_RD1) begin
                right_reg <= rdata_reg;
            end
            if (st_reg == rpn_pkg::S_RD2) begin
                left_reg <= rdata_reg;
            end
            if (st_reg == rpn_pkg::S_DIV && arsp.done) begin
                res_reg <= arsp.value;
                sp_reg <= sp_reg - 1'b1;
                if (sticky_reg == rpn_pkg::ST_OK) begin
                    sticky_reg <= arsp.status;
                end
            end
            if (st_reg == rpn_pkg::S_END) begin
                mv_reg <= 1'b1;
                mval_reg <= (sp_reg == '0) ? 64'd0 : rdata_reg;
                mst_reg <= (sp_reg == '0 && sticky_reg == rpn_pkg::ST_OK) ?
                    rpn_pkg::ST_UNDER : sticky_reg;
                sp_reg <= '0;
                sticky_reg <= rpn_pkg::ST_OK;
            end
        end
    end

`ifndef SYNTHESIS
    a_sp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= rpn_pkg::PTR_W'(rpn_pkg::STACK_DEPTH))
        else $error("stack pointer beyond depth");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg != rpn_pkg::S_IDLE) |-> !s_ready)
        else $error("input taken while busy");
    a_end_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == rpn_pkg::S_END) |=> (m_valid && sp_reg == '0))
        else $error("end token gave no result");
`endif
endmodule
